FILE: rtl/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
// Used by bole_cell and bounded_ordered_list_engine_unit; depends on nothing.
package bole_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Fixed field widths of the request and response channels
   localparam int MODE_W  = 4;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int STAT_W  = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT  = 4'd0,
      MODE_PUSH_BACK   = 4'd1,
      MODE_POP_FRONT   = 4'd2,
      MODE_POP_BACK    = 4'd3,
      MODE_DELETE      = 4'd4,
      MODE_GET         = 4'd5,
      MODE_SET         = 4'd6,
      MODE_SEARCH_HEAD = 4'd7,
      MODE_SEARCH_TAIL = 4'd8
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_BOUND = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_APPLY
   } state_type;

   // What one cell does with its entry at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT,
      CELL_LOAD
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic [DATA_WIDTH-1:0]   key;
   } cell_ctl_type;

endpackage

FILE: rtl/bole_cell.sv
// One list cell: holds a single entry, shifts with its neighbours and
// compares its entry against the broadcast key. Depends on bole_pkg.
module bole_cell (
   input  logic                           clock,
   input  bole_pkg::cell_ctl_type         ctl,
   input  logic [bole_pkg::DATA_WIDTH-1:0] prev_data,
   input  logic [bole_pkg::DATA_WIDTH-1:0] next_data,
   output logic [bole_pkg::DATA_WIDTH-1:0] data_out,
   output logic                           match_out
);
   import bole_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  match_ff;

   // Select the new entry
   always_comb begin
      case (ctl.op)
         CELL_FROM_PREV: data_in = prev_data;
         CELL_FROM_NEXT: data_in = next_data;
         CELL_LOAD:      data_in = ctl.key;
         default:        data_in = data_ff;
      endcase
   end

   // Hold the entry and register the key compare
   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= (data_ff == ctl.key);
   end

   assign data_out  = data_ff;
   assign match_out = match_ff;

endmodule

FILE: rtl/bounded_ordered_list_engine_unit.sv
// Top level of the bounded ordered list engine: request/response control
// and a row of bole_cell instances. Depends on bole_pkg and bole_cell.
//
// Usage
//   The request channel (req_valid, req_stall, req_mode, req_value,
//   req_position) carries one list operation per request. The response
//   channel (rsp_valid, rsp_stall, rsp_status, rsp_read_value,
//   rsp_found_position, rsp_count) returns exactly one response for each
//   request, in order.
//   A request is taken in the idle state. In the compare state every cell
//   compares its entry against the request value; in the apply state the
//   first and last matches are encoded and, once the output register is
//   free, the response is written there and all cells shift or load
//   together. A new request is taken only in the idle state, so requests
//   do not overlap: each passes through the idle, compare and apply
//   states in turn. When the receiver stalls, the held response stays
//   in the output register; req_stall stays high and the cell row waits
//   in the apply step until the output register frees.
//   Reset empties the list (length zero) and drops any pending response;
//   entry contents are not cleared.
module bounded_ordered_list_engine_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [bole_pkg::MODE_W-1:0]  req_mode,
   input  logic [bole_pkg::VALUE_W-1:0] req_value,
   input  logic [bole_pkg::POS_W-1:0]   req_position,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bole_pkg::STAT_W-1:0]  rsp_status,
   output logic [bole_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [bole_pkg::POS_W-1:0]   rsp_found_position,
   output logic [bole_pkg::POS_W-1:0]   rsp_count
);
   import bole_pkg::*;

   state_type             state_ff, state_in;
   logic [MODE_W-1:0]     mode_ff;
   logic [DATA_WIDTH-1:0] key_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [CNT_W-1:0]      occ_ff, occ_in;

   logic                  rsp_valid_ff;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic [VALUE_W-1:0]    rdval_ff, rdval_in;
   logic [POS_W-1:0]      found_ff, found_in;
   logic [POS_W-1:0]      count_ff;

   logic                  req_take;
   logic                  apply_go;

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]      cell_match;
   cell_ctl_type          cell_ctl  [DEPTH];
   cell_op_type           cell_op   [DEPTH];

   logic [DEPTH-1:0]      hit;
   logic [IDX_W-1:0]      first_idx, last_idx;
   logic                  any_hit;
   logic                  full, empty, pos_ok;
   logic [IDX_W-1:0]      rd_idx;
   logic                  rd_en;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign apply_go  = (state_ff == ST_APPLY) && (!rsp_valid_ff || !rsp_stall);

   // Sequence: take request, compare, apply
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CMP;
         ST_CMP:   state_in = ST_APPLY;
         ST_APPLY: if (apply_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_mode;
         key_ff  <= req_value[DATA_WIDTH-1:0];
         pos_ff  <= req_position;
      end
   end

   // Mask matches to occupied positions and encode first and last hit
   always_comb begin
      hit       = '0;
      first_idx = '0;
      last_idx  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit[i] = cell_match[i] && (CNT_W'(i) < occ_ff);
      end
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (hit[i]) first_idx = IDX_W'(i);
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (hit[i]) last_idx = IDX_W'(i);
      end
      any_hit = |hit;
   end

   assign full   = (occ_ff == CNT_W'(DEPTH));
   assign empty  = (occ_ff == '0);
   assign pos_ok = (pos_ff != '0) && (32'(pos_ff) <= 32'(occ_ff));

   // Decide status, read port, new length and cell commands
   always_comb begin
      status_in = STATUS_OK;
      found_in  = '0;
      occ_in    = occ_ff;
      rd_idx    = '0;
      rd_en     = 1'b0;
      for (int i = 0; i < DEPTH; i++) cell_op[i] = CELL_HOLD;
      case (mode_ff)
         MODE_PUSH_FRONT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               occ_in = occ_ff + 1'b1;
               for (int i = 0; i < DEPTH; i++) begin
                  cell_op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_PREV;
               end
            end
         end
         MODE_PUSH_BACK: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               occ_in = occ_ff + 1'b1;
               for (int i = 0; i < DEPTH; i++) begin
                  if (CNT_W'(i) == occ_ff) cell_op[i] = CELL_LOAD;
               end
            end
         end
         MODE_POP_FRONT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               occ_in = occ_ff - 1'b1;
               rd_en  = 1'b1;
               for (int i = 0; i < DEPTH; i++) cell_op[i] = CELL_FROM_NEXT;
            end
         end
         MODE_POP_BACK: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               occ_in = occ_ff - 1'b1;
               rd_en  = 1'b1;
               rd_idx = IDX_W'(occ_ff - 1'b1);
            end
         end
         MODE_DELETE: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else if (!any_hit) begin
               status_in = STATUS_BOUND;
            end else begin
               occ_in = occ_ff - 1'b1;
               rd_en  = 1'b1;
               rd_idx = first_idx;
               for (int i = 0; i < DEPTH; i++) begin
                  if (IDX_W'(i) >= first_idx) cell_op[i] = CELL_FROM_NEXT;
               end
            end
         end
         MODE_GET: begin
            if (!pos_ok) begin
               status_in = STATUS_BOUND;
            end else begin
               rd_en  = 1'b1;
               rd_idx = IDX_W'(pos_ff - 1'b1);
            end
         end
         MODE_SET: begin
            if (!pos_ok) begin
               status_in = STATUS_BOUND;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (IDX_W'(i) == IDX_W'(pos_ff - 1'b1)) cell_op[i] = CELL_LOAD;
               end
            end
         end
         MODE_SEARCH_HEAD: begin
            if (any_hit) found_in = POS_W'(32'(first_idx) + 1);
         end
         MODE_SEARCH_TAIL: begin
            if (any_hit) found_in = POS_W'(32'(occ_ff) - 32'(last_idx));
         end
         default: begin
         end
      endcase
      // Cells only move on the apply edge
      if (!apply_go) begin
         occ_in = occ_ff;
         for (int i = 0; i < DEPTH; i++) cell_op[i] = CELL_HOLD;
      end
   end

   // Single read port of the row
   assign rdval_in = rd_en ? VALUE_W'(cell_data[rd_idx]) : '0;

   // Hold the list length
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // Build the cell row
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_d, next_d;
      if (g == 0) begin : g_head
         assign prev_d = key_ff;
      end else begin : g_mid
         assign prev_d = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign next_d = '0;
      end else begin : g_inner
         assign next_d = cell_data[g+1];
      end
      assign cell_ctl[g].op  = cell_op[g];
      assign cell_ctl[g].key = key_ff;

      bole_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[g]),
         .prev_data (prev_d),
         .next_data (next_d),
         .data_out  (cell_data[g]),
         .match_out (cell_match[g])
      );
   end

   // Output register: load on apply, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (apply_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (apply_go) begin
         status_ff <= status_in;
         rdval_ff  <= rdval_in;
         found_ff  <= found_in;
         count_ff  <= POS_W'(occ_in);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_read_value     = rdval_ff;
   assign rsp_found_position = found_ff;
   assign rsp_count          = count_ff;

   // Length never exceeds the row
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= DEPTH)
      else $error("list length exceeds depth");

   // A full response only comes from a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> 32'(rsp_count) == DEPTH)
      else $error("full status with list not full");

   // A search hit always reports success
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_found_position != '0) |-> rsp_status == STATUS_OK)
      else $error("search hit with error status");

   // Length moves only on the apply edge
   a_occ_apply: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(occ_ff) |-> $past(apply_go))
      else $error("list length changed outside apply");

endmodule
